/* hw/rtl/tpm_pkg.sv */
// Shared types and constants of the tolerance point matcher.
package tpm_pkg;

    typedef enum logic [1:0]
    {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MATCH = 2'd2
    } opcode_t;

    localparam logic [15:0] SAT16   = 16'hFFFF;
    localparam logic [10:0] TOT_MAX = 11'h7FF;

    typedef struct packed
    {
        logic [1:0]  opcode;
        logic [15:0] point_x;
        logic [15:0] point_y;
    } cmd_word_t;

    typedef struct packed
    {
        logic        matched;
        logic [9:0]  match_index;
        logic        table_overflow;
        logic [15:0] bench_total;
        logic [10:0] test_total;
        logic [10:0] match_total;
        logic [15:0] missing_total;
        logic [10:0] false_total;
    } rsp_word_t;

endpackage

/* hw/rtl/tpm_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module tpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/tpm_cmp.sv */
// Square tolerance window test of one stored point against the probe point.
module tpm_cmp #(
    parameter int COORD_BITS = 16
) (
    input  logic                  entry_valid,
    input  logic [COORD_BITS-1:0] entry_x,
    input  logic [COORD_BITS-1:0] entry_y,
    input  logic [COORD_BITS-1:0] probe_x,
    input  logic [COORD_BITS-1:0] probe_y,
    input  logic [15:0]           tol,
    output logic                  hit
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;

    assign dx = (entry_x >= probe_x) ? (entry_x - probe_x) : (probe_x - entry_x);
    assign dy = (entry_y >= probe_y) ? (entry_y - probe_y) : (probe_y - entry_y);

    assign hit = entry_valid && (32'(dx) <= 32'(tol)) && (32'(dy) <= 32'(tol));

endmodule

/* hw/rtl/tolerance_point_matcher_core.sv */
// Top level of the tolerance point matcher: command control, point table and counters.
//
// Each command word on the cmd channel carries an opcode and a point. Clear starts a
// new run, load appends a test point or flags a full table, match scans for the first
// still-valid test point within the square tolerance and claims it. Every command gives
// exactly one response word on the rsp channel with the match result and run totals.
// A word moves when valid is high and stall is low on its channel.
// Clear, load and unused opcodes do their work in the accepting cycle. A match on a
// loaded table reads the table RAM one entry per cycle through its single read port
// and ends at the first hit or once the last loaded entry is checked. The block works
// on one command at a time. A finished response waits in a holding register on its
// way to the output register; cmd_stall is high while a match scans and while the
// holding register is full, so with rsp_stall high one more command is taken and
// then cmd stalls. Reset clears all counters and the run; the table needs no
// clearing because only entries below the load count are read. position_tolerance
// (tol_reg) resets to 2 and is written through cfg_we and cfg_wdata; the user must
// write it only while the block is idle, as the block itself does not enforce
// this.
module tolerance_point_matcher_core #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tpm_pkg::cmd_word_t  cmd_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output tpm_pkg::rsp_word_t  rsp_word,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W = 2 * COORD_BITS + 1;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]       tol_reg, tol_next;
    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic [CNT_W-1:0]  match_cnt_reg, match_cnt_next;
    logic [15:0]       bench_reg, bench_next;
    logic [15:0]       missing_reg, missing_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              pend_reg, pend_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic [COORD_BITS-1:0] qx_reg, qx_next;
    logic [COORD_BITS-1:0] qy_reg, qy_next;
    tpm_pkg::rsp_word_t    pend_word_reg, pend_word_next;
    tpm_pkg::rsp_word_t    rsp_word_reg, rsp_word_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic                  hit;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic                  produce;
    logic                  p_matched;
    logic [9:0]            p_index;
    logic                  p_ovf;

    function automatic logic [10:0] clamp_tot(input logic [CNT_W-1:0] v);
        if (32'(v) > 32'(tpm_pkg::TOT_MAX))
        begin
            return tpm_pkg::TOT_MAX;
        end
        return 11'(v);
    endfunction

    assign cx = COORD_BITS'(cmd_word.point_x);
    assign cy = COORD_BITS'(cmd_word.point_y);

    tpm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(issue_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    tpm_cmp #(
        .COORD_BITS(COORD_BITS)
    ) u_cmp (
        .entry_valid(ram_rdata[ENTRY_W-1]),
        .entry_x    (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
        .entry_y    (ram_rdata[COORD_BITS-1:0]),
        .probe_x    (qx_reg),
        .probe_y    (qy_reg),
        .tol        (tol_reg),
        .hit        (hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        tol_next       = tol_reg;
        loaded_next    = loaded_reg;
        match_cnt_next = match_cnt_reg;
        bench_next     = bench_reg;
        missing_next   = missing_reg;
        issue_next     = issue_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        pend_next      = pend_reg;
        pend_word_next = pend_word_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        produce        = 1'b0;
        p_matched      = 1'b0;
        p_index        = '0;
        p_ovf          = 1'b0;

        if (cfg_we)
        begin
            tol_next = cfg_wdata;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (pend_reg && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = pend_word_reg;
            pend_next      = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !pend_reg)
                begin
                    case (cmd_word.opcode)
                        tpm_pkg::OP_CLEAR:
                        begin
                            loaded_next    = '0;
                            match_cnt_next = '0;
                            bench_next     = '0;
                            missing_next   = '0;
                            produce        = 1'b1;
                        end
                        tpm_pkg::OP_LOAD:
                        begin
                            if (loaded_reg < CNT_W'(MAX_POINTS))
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = loaded_reg[IDX_W-1:0];
                                ram_wdata   = {1'b1, cx, cy};
                                loaded_next = loaded_reg + CNT_W'(1);
                            end
                            else
                            begin
                                p_ovf = 1'b1;
                            end
                            produce = 1'b1;
                        end
                        tpm_pkg::OP_MATCH:
                        begin
                            if (bench_reg != tpm_pkg::SAT16)
                            begin
                                bench_next = bench_reg + 16'd1;
                            end
                            qx_next = cx;
                            qy_next = cy;
                            if (loaded_reg == '0)
                            begin
                                if (missing_reg != tpm_pkg::SAT16)
                                begin
                                    missing_next = missing_reg + 16'd1;
                                end
                                produce = 1'b1;
                            end
                            else
                            begin
                                state_next   = ST_SCAN;
                                issue_next   = '0;
                                chk_vld_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (chk_vld_reg && hit)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = chk_idx_reg;
                    ram_wdata      = {1'b0, ram_rdata[ENTRY_W-2:0]};
                    match_cnt_next = match_cnt_reg + CNT_W'(1);
                    p_matched      = 1'b1;
                    p_index        = 10'(chk_idx_reg);
                    produce        = 1'b1;
                    chk_vld_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
                else if (chk_vld_reg && (CNT_W'(chk_idx_reg) + CNT_W'(1) == loaded_reg))
                begin
                    if (missing_reg != tpm_pkg::SAT16)
                    begin
                        missing_next = missing_reg + 16'd1;
                    end
                    produce      = 1'b1;
                    chk_vld_next = 1'b0;
                    state_next   = ST_IDLE;
                end
                else if (issue_reg < loaded_reg)
                begin
                    ram_re       = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = issue_reg[IDX_W-1:0];
                    issue_next   = issue_reg + CNT_W'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (produce)
        begin
            pend_next                     = 1'b1;
            pend_word_next.matched        = p_matched;
            pend_word_next.match_index    = p_index;
            pend_word_next.table_overflow = p_ovf;
            pend_word_next.bench_total    = bench_next;
            pend_word_next.test_total     = clamp_tot(loaded_next);
            pend_word_next.match_total    = clamp_tot(match_cnt_next);
            pend_word_next.missing_total  = missing_next;
            pend_word_next.false_total    = clamp_tot(loaded_next - match_cnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= 16'd2;
            loaded_reg    <= '0;
            match_cnt_reg <= '0;
            bench_reg     <= '0;
            missing_reg   <= '0;
            issue_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tol_reg       <= tol_next;
            loaded_reg    <= loaded_next;
            match_cnt_reg <= match_cnt_next;
            bench_reg     <= bench_next;
            missing_reg   <= missing_next;
            issue_reg     <= issue_next;
            chk_vld_reg   <= chk_vld_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        pend_word_reg <= pend_word_next;
        rsp_word_reg  <= rsp_word_next;
    end

    assign cmd_stall = (state_reg != ST_IDLE) || pend_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

/* hw/rtl/tpm_checker.sv */
// Port-level checker of the tolerance point matcher and its bind to the top level.
module tpm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input tpm_pkg::rsp_word_t rsp_word
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("Stalled response word changed or was dropped.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("Command accepted while the previous one was still in work.");

    a_totals_agree: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.test_total != tpm_pkg::TOT_MAX) |->
        (12'(rsp_word.false_total) + 12'(rsp_word.match_total) ==
         12'(rsp_word.test_total)))
        else $error("False and match totals do not add up to the load total.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_word.matched && rsp_word.table_overflow) &&
        (rsp_word.matched || (rsp_word.match_index == 10'd0)))
        else $error("Response flags or match index are inconsistent.");

    a_missing_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_word.missing_total <= rsp_word.bench_total)
        else $error("Missing total exceeds bench total.");

endmodule

bind tolerance_point_matcher_core tpm_checker u_tpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word (rsp_word)
);
